/* sv/spmr_pkg.sv */
// shared types and constants of the sparse polynomial reduction block
// no dependencies; every other file refers to this package by scoped names

package spmr_pkg;

	// coefficient and register field widths
	localparam int COEF_BITS    = 16;
	localparam int DEG_BITS     = 6;
	localparam int CNT_BITS     = 3;
	localparam int POS_BITS     = 5;
	localparam int PACKED_TERMS = 4;
	localparam int POSV_BITS    = POS_BITS * PACKED_TERMS;
	localparam int TCOEF_BITS   = COEF_BITS * PACKED_TERMS;

	// limits of the reduction
	localparam int MAX_TERMS   = 4;
	localparam int MAX_DEGREE  = 32;
	localparam int STORE_DEPTH = 64;

	// queue depths between the parts
	localparam int IN_QUEUE_DEPTH  = 4;
	localparam int OUT_QUEUE_DEPTH = 2;

	// configuration port
	localparam int DATA_BITS    = 64;
	localparam int ADDR_BITS    = 6;
	localparam int REG_IDX_BITS = ADDR_BITS - 3;

	localparam logic [REG_IDX_BITS-1:0] REG_PRIME     = REG_IDX_BITS'(0);
	localparam logic [REG_IDX_BITS-1:0] REG_DEGREE    = REG_IDX_BITS'(1);
	localparam logic [REG_IDX_BITS-1:0] REG_TERM_CNT  = REG_IDX_BITS'(2);
	localparam logic [REG_IDX_BITS-1:0] REG_TERM_POS  = REG_IDX_BITS'(3);
	localparam logic [REG_IDX_BITS-1:0] REG_TERM_COEF = REG_IDX_BITS'(4);

	// configuration register file
	typedef struct packed {
		logic [COEF_BITS-1:0]  prime_modulus;
		logic [DEG_BITS-1:0]   field_degree;
		logic [CNT_BITS-1:0]   lower_term_count;
		logic [POSV_BITS-1:0]  term_positions;
		logic [TCOEF_BITS-1:0] term_coeffs;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		prime_modulus:    COEF_BITS'(2),
		field_degree:     DEG_BITS'(1),
		lower_term_count: CNT_BITS'(1),
		term_positions:   '0,
		term_coeffs:      '0
	};

	// classified load request from the front to the back
	typedef struct packed {
		logic [COEF_BITS-1:0] coef;
		logic                 is_last;
		logic                 drop;
		logic                 ovf;
	} load_req_t;

	// one residue coefficient on its way out
	typedef struct packed {
		logic [COEF_BITS-1:0] residue;
		logic                 last;
		logic                 ovf;
	} res_t;

endpackage

/* sv/spmr_ram.sv */
// generic single-write, single-read ram with registered read data
// depends on spmr_pkg for default sizes only

module spmr_ram #(
	parameter int WIDTH = spmr_pkg::COEF_BITS,
	parameter int DEPTH = spmr_pkg::STORE_DEPTH
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* sv/spmr_fifo.sv */
// small register queue with full and empty flags
// depends on spmr_pkg for default sizes only

module spmr_fifo #(
	parameter int WIDTH = spmr_pkg::COEF_BITS,
	parameter int DEPTH = spmr_pkg::IN_QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wp_q, rp_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CNT_FULL);
	assign empty   = (cnt_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = mem_q[rp_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == PTR_LAST) ? '0 : wp_q + PW'(1);
			end
			if (do_pop) begin
				rp_q <= (rp_q == PTR_LAST) ? '0 : rp_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

/* sv/spmr_modmul.sv */
// bit-serial modular multiplier: r = (a * b) mod p, one bit of b per cycle
// depends on spmr_pkg; needs a below p, b may hold any value

module spmr_modmul (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [spmr_pkg::COEF_BITS-1:0] a,
	input  logic [spmr_pkg::COEF_BITS-1:0] b,
	input  logic [spmr_pkg::COEF_BITS-1:0] p,
	output logic                           done,
	output logic [spmr_pkg::COEF_BITS-1:0] r
);

	localparam int W  = spmr_pkg::COEF_BITS;
	localparam int SW = $clog2(W);
	localparam logic [SW-1:0] STEP_LAST = SW'(W - 1);

	logic [W-1:0]  a_q, b_q, p_q, r_q;
	logic [SW-1:0] step_q;
	logic          busy_q, done_q;
	logic [W:0]    dbl, dbl_red, sum, sum_red;
	logic [W-1:0]  r_next;

	// one step: double, reduce, conditionally add a, reduce
	always_comb begin
		dbl     = {r_q, 1'b0};
		dbl_red = (dbl >= {1'b0, p_q}) ? dbl - {1'b0, p_q} : dbl;
		sum     = dbl_red + {1'b0, a_q};
		sum_red = (sum >= {1'b0, p_q}) ? sum - {1'b0, p_q} : sum;
		r_next  = b_q[W-1] ? sum_red[W-1:0] : dbl_red[W-1:0];
	end

	// operand and partial result registers
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			p_q <= p;
			r_q <= '0;
		end else if (busy_q) begin
			r_q <= r_next;
			b_q <= {b_q[W-2:0], 1'b0};
		end
	end

	// step sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + SW'(1);
				if (step_q == STEP_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign r    = r_q;

endmodule

/* sv/spmr_front.sv */
// front part: accepts coefficients, tracks the fill level of the store and
// marks each request as stored or dropped; depends on spmr_pkg

module spmr_front #(
	parameter int STORE_DEPTH = spmr_pkg::STORE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [spmr_pkg::COEF_BITS-1:0] coefficient,
	input  logic                           final_coeff,
	output logic                           q_push,
	output spmr_pkg::load_req_t            q_req,
	input  logic                           q_full
);

	localparam int CW = $clog2(STORE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);

	logic [CW-1:0] fill_q;
	logic          ovf_q;
	logic          room;

	// classify the incoming request
	assign full   = q_full;
	assign q_push = push & ~q_full;
	assign room   = (fill_q < DEPTH_C);

	always_comb begin
		q_req.coef    = coefficient;
		q_req.is_last = final_coeff;
		q_req.drop    = ~room;
		q_req.ovf     = ovf_q | ~room;
	end

	// fill level and sticky overflow of the polynomial being loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			ovf_q  <= 1'b0;
		end else if (q_push) begin
			if (final_coeff) begin
				fill_q <= '0;
				ovf_q  <= 1'b0;
			end else if (room) begin
				fill_q <= fill_q + CW'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

endmodule

/* sv/spmr_back.sv */
// back part: writes requests into the coefficient store, reduces the
// polynomial and emits the residue; depends on spmr_pkg, spmr_ram, spmr_modmul

module spmr_back #(
	parameter int STORE_DEPTH = spmr_pkg::STORE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  spmr_pkg::cfg_t      cfg,
	input  logic                req_valid,
	input  spmr_pkg::load_req_t req,
	output logic                req_pop,
	output logic                res_push,
	output spmr_pkg::res_t      res,
	input  logic                res_full
);

	localparam int W         = spmr_pkg::COEF_BITS;
	localparam int DW        = spmr_pkg::DEG_BITS;
	localparam int AW        = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CW        = $clog2(STORE_DEPTH + 1);
	localparam int LIM       = (spmr_pkg::MAX_DEGREE < STORE_DEPTH) ?
	                           spmr_pkg::MAX_DEGREE : STORE_DEPTH;
	localparam int LIM_SAT   = (LIM > (2 ** DW) - 1) ? (2 ** DW) - 1 : LIM;
	localparam int TERMS_LIM = (spmr_pkg::MAX_TERMS < spmr_pkg::PACKED_TERMS) ?
	                           spmr_pkg::MAX_TERMS : spmr_pkg::PACKED_TERMS;
	localparam int KW        = $clog2(TERMS_LIM + 1);
	localparam int TIW       = (spmr_pkg::PACKED_TERMS > 1) ?
	                           $clog2(spmr_pkg::PACKED_TERMS) : 1;
	localparam logic [DW-1:0] LIM_D = DW'(LIM_SAT);
	localparam logic [W-1:0]  P_MIN = W'(2);
	localparam logic [W-1:0]  ONE   = W'(1);

	typedef enum logic [8:0] {
		ST_LOAD  = 9'b000000001,
		ST_URD   = 9'b000000010,
		ST_ULAT  = 9'b000000100,
		ST_UCALC = 9'b000001000,
		ST_CRD   = 9'b000010000,
		ST_CLAT  = 9'b000100000,
		ST_TSEL  = 9'b001000000,
		ST_ORD   = 9'b010000000,
		ST_OPUSH = 9'b100000000
	} state_t;

	state_t        state_q;
	logic [CW-1:0] n_q;
	logic          ovf_q;
	logic [W-1:0]  p_q, c_q, old_q, tcoef_q;
	logic [DW-1:0] d_q;
	logic [KW-1:0] terms_q, kcnt_q;
	logic          mode_mod_q;
	logic [AW-1:0] idx_q, i_q, addr_q;

	logic                         ram_we, ram_re;
	logic [AW-1:0]                ram_waddr, ram_raddr;
	logic [W-1:0]                 ram_wdata, ram_rdata;
	logic                         mm_start, mm_done;
	logic [W-1:0]                 mm_a, mm_b, mm_r;
	logic [spmr_pkg::POS_BITS-1:0] pos_arr [spmr_pkg::PACKED_TERMS];
	logic [W-1:0]                 tc_arr  [spmr_pkg::PACKED_TERMS];
	logic [TIW-1:0]               k_idx;
	logic [W-1:0]                 p_eff, upd;
	logic [DW-1:0]                d_eff;
	logic [KW-1:0]                terms_eff;
	logic [AW-1:0]                t_addr;
	logic                         out_last, mod_end;

	// coefficient store
	spmr_ram #(
		.WIDTH (W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// shared modular multiplier
	spmr_modmul u_modmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm_start),
		.a      (mm_a),
		.b      (mm_b),
		.p      (p_q),
		.done   (mm_done),
		.r      (mm_r)
	);

	// unpack the lower terms of the modulus
	always_comb begin
		for (int j = 0; j < spmr_pkg::PACKED_TERMS; j++) begin
			pos_arr[j] = cfg.term_positions[j*spmr_pkg::POS_BITS +: spmr_pkg::POS_BITS];
			tc_arr[j]  = cfg.term_coeffs[j*W +: W];
		end
	end

	// effective modulus, degree and term count
	always_comb begin
		p_eff = (cfg.prime_modulus < P_MIN) ? P_MIN : cfg.prime_modulus;
		if (cfg.field_degree == '0) begin
			d_eff = DW'(1);
		end else if (cfg.field_degree > LIM_D) begin
			d_eff = LIM_D;
		end else begin
			d_eff = cfg.field_degree;
		end
		terms_eff = (cfg.lower_term_count > spmr_pkg::CNT_BITS'(TERMS_LIM)) ?
		            KW'(TERMS_LIM) : KW'(cfg.lower_term_count);
	end

	// term selection, target address and the subtract step
	assign k_idx    = TIW'(kcnt_q - KW'(1));
	assign t_addr   = AW'(pos_arr[k_idx]) + i_q - AW'(d_q);
	assign upd      = (old_q >= mm_r) ? old_q - mm_r : old_q + (p_q - mm_r);
	assign out_last = ((CW'(idx_q) + CW'(1)) == CW'(d_q));
	assign mod_end  = ((CW'(addr_q) + CW'(1)) == n_q);

	// result fields; entries at or above the fill count read as zero
	always_comb begin
		res.residue = (CW'(idx_q) < n_q) ? ram_rdata : '0;
		res.last    = out_last;
		res.ovf     = ovf_q;
	end

	// store, multiplier and queue strobes
	always_comb begin
		req_pop   = 1'b0;
		res_push  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = upd;
		ram_re    = 1'b0;
		ram_raddr = addr_q;
		mm_start  = 1'b0;
		mm_a      = c_q;
		mm_b      = tcoef_q;
		case (state_q)
			ST_LOAD: begin
				if (req_valid) begin
					req_pop = 1'b1;
					if (!req.drop) begin
						ram_we    = 1'b1;
						ram_waddr = AW'(n_q);
						ram_wdata = req.coef;
					end
				end
			end
			ST_URD: begin
				ram_re = 1'b1;
			end
			ST_ULAT: begin
				mm_start = 1'b1;
				if (mode_mod_q) begin
					mm_a = ONE;
					mm_b = ram_rdata;
				end
			end
			ST_UCALC: begin
				if (mm_done) begin
					ram_we    = 1'b1;
					ram_wdata = mode_mod_q ? mm_r : upd;
				end
			end
			ST_CRD: begin
				ram_re    = 1'b1;
				ram_raddr = i_q;
			end
			ST_ORD: begin
				ram_re    = 1'b1;
				ram_raddr = idx_q;
			end
			ST_OPUSH: begin
				res_push = ~res_full;
			end
			default: begin
			end
		endcase
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				if (req_valid && req.is_last) begin
					ovf_q      <= req.ovf;
					p_q        <= p_eff;
					d_q        <= d_eff;
					terms_q    <= terms_eff;
					mode_mod_q <= 1'b1;
					addr_q     <= '0;
				end
			end
			ST_ULAT: begin
				old_q <= ram_rdata;
			end
			ST_UCALC: begin
				if (mm_done && mode_mod_q) begin
					addr_q <= addr_q + AW'(1);
					i_q    <= AW'(n_q - CW'(1));
					idx_q  <= '0;
				end
			end
			ST_CLAT: begin
				c_q    <= ram_rdata;
				kcnt_q <= terms_q;
			end
			ST_TSEL: begin
				if (kcnt_q == '0) begin
					i_q   <= i_q - AW'(1);
					idx_q <= '0;
				end else begin
					kcnt_q     <= kcnt_q - KW'(1);
					addr_q     <= t_addr;
					tcoef_q    <= tc_arr[k_idx];
					mode_mod_q <= 1'b0;
				end
			end
			ST_OPUSH: begin
				if (!res_full) begin
					idx_q <= idx_q + AW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			n_q     <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (req_valid) begin
						if (!req.drop) begin
							n_q <= n_q + CW'(1);
						end
						if (req.is_last) begin
							state_q <= ST_URD;
						end
					end
				end
				ST_URD: begin
					state_q <= ST_ULAT;
				end
				ST_ULAT: begin
					state_q <= ST_UCALC;
				end
				ST_UCALC: begin
					if (mm_done) begin
						if (!mode_mod_q) begin
							state_q <= ST_TSEL;
						end else if (!mod_end) begin
							state_q <= ST_URD;
						end else if (n_q > CW'(d_q)) begin
							state_q <= ST_CRD;
						end else begin
							state_q <= ST_ORD;
						end
					end
				end
				ST_CRD: begin
					state_q <= ST_CLAT;
				end
				ST_CLAT: begin
					state_q <= ST_TSEL;
				end
				ST_TSEL: begin
					if (kcnt_q == '0) begin
						state_q <= (i_q == d_q) ? ST_ORD : ST_CRD;
					end else if (DW'(pos_arr[k_idx]) < d_q) begin
						state_q <= ST_URD;
					end
				end
				ST_ORD: begin
					state_q <= ST_OPUSH;
				end
				ST_OPUSH: begin
					if (!res_full) begin
						if (out_last) begin
							state_q <= ST_LOAD;
							n_q     <= '0;
						end else begin
							state_q <= ST_ORD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

/* sv/sparse_poly_mod_reduce.sv */
// top level of the sparse polynomial reduction block with its register port
// depends on spmr_pkg, spmr_front, spmr_fifo, spmr_back

// The block loads polynomial coefficients over Z/pZ, lowest degree first, one
// per cycle while the request queue has room, into a coefficient store of
// STORE_DEPTH entries, behind a four-entry request queue; coefficients past
// the store size are dropped and every residue of that polynomial then carries
// overflowed. The request flagged final_coeff starts the reduction by x^d +
// sum a_k x^(j_k), with the modulus, degree and term count in force at that
// moment. All the modular arithmetic runs on one bit-serial multiplier of 16
// steps. The block reduces all n stored coefficients mod p, folds those from
// degree n-1 down to d into the lower terms with j_k below d, one store update
// per term, then emits the d residue coefficients; the store stays busy over
// that span while new requests collect in the queue. No clearing pass is
// needed: a fill count makes unwritten entries read as zero. Registers sit at
// byte addresses 0, 8, 16, 24 and 32 of the 64-bit port.

module sparse_poly_mod_reduce #(
	parameter int STORE_DEPTH = spmr_pkg::STORE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [spmr_pkg::COEF_BITS-1:0] coefficient,
	input  logic                           final_coeff,
	output logic                           empty,
	input  logic                           pop,
	output logic [spmr_pkg::COEF_BITS-1:0] residue_coeff,
	output logic                           last_out,
	output logic                           overflowed,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [spmr_pkg::ADDR_BITS-1:0] paddr,
	input  logic [spmr_pkg::DATA_BITS-1:0] pwdata,
	output logic [spmr_pkg::DATA_BITS-1:0] prdata,
	output logic                           pready
);

	spmr_pkg::cfg_t      cfg_q;
	spmr_pkg::load_req_t in_req, in_head;
	spmr_pkg::res_t      res_tail, res_head;
	logic                in_q_push, in_q_full, in_q_empty, req_pop;
	logic                res_push, res_full;
	logic                cfg_wr;
	logic [spmr_pkg::REG_IDX_BITS-1:0] reg_idx;

	// register port decode
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign reg_idx = paddr[spmr_pkg::ADDR_BITS-1:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= spmr_pkg::CFG_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				spmr_pkg::REG_PRIME: begin
					cfg_q.prime_modulus <= pwdata[spmr_pkg::COEF_BITS-1:0];
				end
				spmr_pkg::REG_DEGREE: begin
					cfg_q.field_degree <= pwdata[spmr_pkg::DEG_BITS-1:0];
				end
				spmr_pkg::REG_TERM_CNT: begin
					cfg_q.lower_term_count <= pwdata[spmr_pkg::CNT_BITS-1:0];
				end
				spmr_pkg::REG_TERM_POS: begin
					cfg_q.term_positions <= pwdata[spmr_pkg::POSV_BITS-1:0];
				end
				spmr_pkg::REG_TERM_COEF: begin
					cfg_q.term_coeffs <= pwdata[spmr_pkg::TCOEF_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// register readback
	always_comb begin
		case (reg_idx)
			spmr_pkg::REG_PRIME:     prdata = spmr_pkg::DATA_BITS'(cfg_q.prime_modulus);
			spmr_pkg::REG_DEGREE:    prdata = spmr_pkg::DATA_BITS'(cfg_q.field_degree);
			spmr_pkg::REG_TERM_CNT:  prdata = spmr_pkg::DATA_BITS'(cfg_q.lower_term_count);
			spmr_pkg::REG_TERM_POS:  prdata = spmr_pkg::DATA_BITS'(cfg_q.term_positions);
			spmr_pkg::REG_TERM_COEF: prdata = spmr_pkg::DATA_BITS'(cfg_q.term_coeffs);
			default:                 prdata = '0;
		endcase
	end

	// front: accept and classify
	spmr_front #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.coefficient (coefficient),
		.final_coeff (final_coeff),
		.q_push      (in_q_push),
		.q_req       (in_req),
		.q_full      (in_q_full)
	);

	// request queue between front and back
	spmr_fifo #(
		.WIDTH ($bits(spmr_pkg::load_req_t)),
		.DEPTH (spmr_pkg::IN_QUEUE_DEPTH)
	) u_req_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (in_q_push),
		.wdata  (in_req),
		.full   (in_q_full),
		.pop    (req_pop),
		.rdata  (in_head),
		.empty  (in_q_empty)
	);

	// back: store, reduce, emit
	spmr_back #(
		.STORE_DEPTH (STORE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.req_valid (~in_q_empty),
		.req       (in_head),
		.req_pop   (req_pop),
		.res_push  (res_push),
		.res       (res_tail),
		.res_full  (res_full)
	);

	// result queue towards the consumer
	spmr_fifo #(
		.WIDTH ($bits(spmr_pkg::res_t)),
		.DEPTH (spmr_pkg::OUT_QUEUE_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_tail),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_head),
		.empty  (empty)
	);

	assign residue_coeff = res_head.residue;
	assign last_out      = res_head.last;
	assign overflowed    = res_head.ovf;

	// back never pops an empty request queue
	assert property (@(posedge clk) disable iff (!arst_n) req_pop |-> !in_q_empty)
		else $error("request popped from empty queue");

	// back never pushes into a full result queue
	assert property (@(posedge clk) disable iff (!arst_n) res_push |-> !res_full)
		else $error("result pushed into full queue");

	// front only forwards a request when the queue has room
	assert property (@(posedge clk) disable iff (!arst_n) in_q_push |-> !in_q_full)
		else $error("request pushed into full queue");

endmodule

/* tb/sparse_poly_mod_reduce_tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for sparse_poly_mod_reduce: directed and random polynomials
// depends on spmr_pkg and the block's rtl; residues are predicted in-line and compared

module sparse_poly_mod_reduce_tb;

	localparam int WATCHDOG_LIMIT = 40000;
	localparam int SETTLE_CYCLES  = 40;
	localparam int RANDOM_ITEMS   = 80;
	localparam int DEG_LIMIT      = (spmr_pkg::MAX_DEGREE < spmr_pkg::STORE_DEPTH) ?
	                                spmr_pkg::MAX_DEGREE : spmr_pkg::STORE_DEPTH;

	logic                           clk;
	logic                           arst_n;
	logic                           push;
	logic                           full;
	logic [spmr_pkg::COEF_BITS-1:0] coefficient;
	logic                           final_coeff;
	logic                           empty;
	logic                           pop;
	logic [spmr_pkg::COEF_BITS-1:0] residue_coeff;
	logic                           last_out;
	logic                           overflowed;
	logic                           psel;
	logic                           penable;
	logic                           pwrite;
	logic [spmr_pkg::ADDR_BITS-1:0] paddr;
	logic [spmr_pkg::DATA_BITS-1:0] pwdata;
	logic [spmr_pkg::DATA_BITS-1:0] prdata;
	logic                           pready;

	sparse_poly_mod_reduce dut (.*);

	// shadow registers and coefficient store of the prediction
	spmr_pkg::cfg_t               reg_shadow = spmr_pkg::CFG_RESET;
	bit [spmr_pkg::COEF_BITS-1:0] poly_store [spmr_pkg::STORE_DEPTH];
	int                           poly_len = 0;
	bit                           poly_overflow = 1'b0;
	spmr_pkg::res_t               pending_residues [$];

	int          error_count = 0;
	int          items_sent = 0;
	int unsigned idle_cycles = 0;
	bit          send_gaps_on = 1'b1;
	bit          pop_stalls_on = 1'b1;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// store one coefficient; on the final one fold the top terms and queue the residues
	task automatic predict_residues(input logic [spmr_pkg::COEF_BITS-1:0] c, input logic fin);
		longint unsigned p;
		longint unsigned top;
		longint unsigned sum;
		longint unsigned neg [spmr_pkg::MAX_TERMS];
		int              pos [spmr_pkg::MAX_TERMS];
		int              deg;
		int              nterms;
		int              t;
		int              i;
		int              k;
		spmr_pkg::res_t  r;
		if (poly_len < spmr_pkg::STORE_DEPTH) begin
			poly_store[poly_len] = c;
			poly_len++;
		end else begin
			poly_overflow = 1'b1;
		end
		if (!fin)
			return;

		// effective modulus, degree and term count after saturation
		p = (reg_shadow.prime_modulus < 2) ? 2 : reg_shadow.prime_modulus;
		deg = reg_shadow.field_degree;
		if (deg < 1)
			deg = 1;
		if (deg > DEG_LIMIT)
			deg = DEG_LIMIT;
		nterms = reg_shadow.lower_term_count;
		if (nterms > spmr_pkg::MAX_TERMS)
			nterms = spmr_pkg::MAX_TERMS;
		for (k = 0; k < nterms; k++) begin
			pos[k] = reg_shadow.term_positions[spmr_pkg::POS_BITS*k +: spmr_pkg::POS_BITS];
			neg[k] = (p - reg_shadow.term_coeffs[spmr_pkg::COEF_BITS*k +: spmr_pkg::COEF_BITS]
			          % p) % p;
		end

		for (k = 0; k < poly_len; k++)
			poly_store[k] = poly_store[k] % p;

		// fold each top coefficient into the lower terms, highest degree first
		for (i = poly_len - 1; i >= deg; i--) begin
			top = poly_store[i];
			for (k = nterms - 1; k >= 0; k--) begin
				if (pos[k] < deg) begin
					t = pos[k] + i - deg;
					sum = poly_store[t] + top * neg[k];
					poly_store[t] = sum % p;
				end
			end
			poly_store[i] = '0;
		end

		for (k = 0; k < deg; k++) begin
			r.residue = poly_store[k];
			r.last    = (k == deg - 1);
			r.ovf     = poly_overflow;
			pending_residues.push_back(r);
		end

		// next polynomial starts from a clean store
		for (k = 0; k < spmr_pkg::STORE_DEPTH; k++)
			poly_store[k] = '0;
		poly_len = 0;
		poly_overflow = 1'b0;
	endtask

	// apb write: setup cycle, then access cycle
	task automatic write_reg(input logic [spmr_pkg::REG_IDX_BITS-1:0] idx,
	                         input logic [spmr_pkg::DATA_BITS-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			spmr_pkg::REG_PRIME:
				reg_shadow.prime_modulus    = value[spmr_pkg::COEF_BITS-1:0];
			spmr_pkg::REG_DEGREE:
				reg_shadow.field_degree     = value[spmr_pkg::DEG_BITS-1:0];
			spmr_pkg::REG_TERM_CNT:
				reg_shadow.lower_term_count = value[spmr_pkg::CNT_BITS-1:0];
			spmr_pkg::REG_TERM_POS:
				reg_shadow.term_positions   = value[spmr_pkg::POSV_BITS-1:0];
			spmr_pkg::REG_TERM_COEF:
				reg_shadow.term_coeffs      = value[spmr_pkg::TCOEF_BITS-1:0];
			default: ;
		endcase
	endtask

	task automatic write_config(input logic [spmr_pkg::COEF_BITS-1:0] p,
	                            input logic [spmr_pkg::DEG_BITS-1:0] d,
	                            input logic [spmr_pkg::CNT_BITS-1:0] cnt,
	                            input logic [spmr_pkg::POSV_BITS-1:0] pos,
	                            input logic [spmr_pkg::TCOEF_BITS-1:0] coefs);
		write_reg(spmr_pkg::REG_PRIME, spmr_pkg::DATA_BITS'(p));
		write_reg(spmr_pkg::REG_DEGREE, spmr_pkg::DATA_BITS'(d));
		write_reg(spmr_pkg::REG_TERM_CNT, spmr_pkg::DATA_BITS'(cnt));
		write_reg(spmr_pkg::REG_TERM_POS, spmr_pkg::DATA_BITS'(pos));
		write_reg(spmr_pkg::REG_TERM_COEF, spmr_pkg::DATA_BITS'(coefs));
	endtask

	// one coefficient request; full is sampled mid-cycle, acceptance at the next edge
	task automatic send_coeff(input logic [spmr_pkg::COEF_BITS-1:0] c, input logic fin);
		int gap;
		bit taken;
		gap = send_gaps_on ? $urandom_range(0, 4) : 0;
		repeat (gap) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push        <= 1'b1;
		coefficient <= c;
		final_coeff <= fin;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !full;
			@(posedge clk);
		end
		predict_residues(c, fin);
		items_sent++;
	endtask

	// stop sending and wait until every predicted residue has come back
	task automatic drain_results();
		push <= 1'b0;
		while (pending_residues.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic check_residue(input spmr_pkg::res_t seen);
		spmr_pkg::res_t want;
		if (pending_residues.size() == 0) begin
			$display("%0t: unexpected residue %0d last_out %0b overflowed %0b",
			         $time, seen.residue, seen.last, seen.ovf);
			error_count++;
			return;
		end
		want = pending_residues.pop_front();
		if (seen.residue !== want.residue) begin
			$display("%0t: residue_coeff expected %0d actual %0d", $time, want.residue,
			         seen.residue);
			error_count++;
		end
		if (seen.last !== want.last) begin
			$display("%0t: last_out expected %0b actual %0b", $time, want.last, seen.last);
			error_count++;
		end
		if (seen.ovf !== want.ovf) begin
			$display("%0t: overflowed expected %0b actual %0b", $time, want.ovf, seen.ovf);
			error_count++;
		end
	endtask

	// result side: random pop stalls, residue sampled mid-cycle
	initial begin : residue_sink
		int             stall;
		bit             got;
		spmr_pkg::res_t seen;
		pop <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = pop_stalls_on ? $urandom_range(0, 4) : 0;
			repeat (stall) begin
				pop <= 1'b0;
				@(posedge clk);
			end
			pop <= 1'b1;
			got = 1'b0;
			while (!got) begin
				@(negedge clk);
				got = !empty;
				seen.residue = residue_coeff;
				seen.last    = last_out;
				seen.ovf     = overflowed;
				@(posedge clk);
			end
			check_residue(seen);
		end
	end

	// watchdog on cycles without any accepted request or popped residue
	initial begin : watchdog
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(negedge clk);
			if ((push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// registers as they come out of reset
	task automatic test_reset_registers();
		send_coeff(16'hFFFF, 1'b1);
		send_coeff(16'd3, 1'b0);
		send_coeff(16'd5, 1'b0);
		send_coeff(16'hFFFF, 1'b1);
		drain_results();
	endtask

	// largest modulus and degree, then degree one with a large prime
	task automatic test_register_extremes();
		int i;
		write_config(16'hFFFF, 6'd32, 3'd4, {5'd30, 5'd15, 5'd0, 5'd31},
		             64'hFFFE_8000_0001_FFFF);
		for (i = 0; i < 33; i++)
			send_coeff((i % 3 == 0) ? 16'hFFFE : (i % 3 == 1) ? 16'h0001 : 16'hFFFF, i == 32);
		drain_results();
		write_config(16'd65521, 6'd1, 3'd1, 20'd0, 64'd1);
		send_coeff(16'd65520, 1'b0);
		send_coeff(16'd1, 1'b0);
		send_coeff(16'hFFFF, 1'b1);
		drain_results();
	endtask

	// modulus below two, degree zero and too large, term counts zero and too large,
	// positions at or above the degree, term coefficients not below the modulus
	task automatic test_odd_registers();
		int i;
		write_config(16'd1, 6'd0, 3'd0, 20'd0, 64'd0);
		send_coeff(16'd7, 1'b0);
		send_coeff(16'd9, 1'b0);
		send_coeff(16'hFFFF, 1'b1);
		drain_results();
		write_config(16'd0, 6'd63, 3'd7, 20'hFFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		for (i = 0; i < 33; i++)
			send_coeff(spmr_pkg::COEF_BITS'(i * 2049 + 1), i == 32);
		drain_results();
		write_config(16'd5, 6'd4, 3'd2, {10'd0, 5'd2, 5'd7}, 64'h0000_0000_000C_0009);
		send_coeff(16'hFFFF, 1'b0);
		send_coeff(16'd4, 1'b0);
		send_coeff(16'h8000, 1'b0);
		send_coeff(16'd3, 1'b0);
		send_coeff(16'h7FFF, 1'b0);
		send_coeff(16'd2, 1'b0);
		send_coeff(16'd1, 1'b0);
		send_coeff(16'hFFFF, 1'b1);
		drain_results();
	endtask

	// dropped final coefficient, then a short polynomial, then a store filled exactly
	task automatic test_store_overflow();
		int i;
		write_config(16'd97, 6'd3, 3'd2, {10'd0, 5'd1, 5'd0}, 64'h0000_0000_005A_0005);
		for (i = 0; i < spmr_pkg::STORE_DEPTH + 2; i++)
			send_coeff(spmr_pkg::COEF_BITS'($urandom_range(0, 96)),
			           i == spmr_pkg::STORE_DEPTH + 1);
		for (i = 0; i < 4; i++)
			send_coeff(spmr_pkg::COEF_BITS'(i + 1), i == 3);
		drain_results();
		for (i = 0; i < spmr_pkg::STORE_DEPTH; i++)
			send_coeff(spmr_pkg::COEF_BITS'($urandom_range(0, 96)),
			           i == spmr_pkg::STORE_DEPTH - 1);
		drain_results();
	endtask

	// random register settings, each followed by a run of random polynomials
	task automatic test_random_polys();
		int                              start_count;
		int                              peff;
		int                              deg_eff;
		int                              npolys;
		int                              plen;
		int                              j;
		int                              k;
		logic [spmr_pkg::COEF_BITS-1:0]  p;
		logic [spmr_pkg::DEG_BITS-1:0]   d;
		logic [spmr_pkg::CNT_BITS-1:0]   cnt;
		logic [spmr_pkg::POSV_BITS-1:0]  pos;
		logic [spmr_pkg::TCOEF_BITS-1:0] coefs;
		logic [spmr_pkg::COEF_BITS-1:0]  c;
		start_count = items_sent;
		while (items_sent - start_count < RANDOM_ITEMS) begin
			case ($urandom_range(0, 7))
				0: p = 16'd0;
				1: p = 16'd1;
				2: p = 16'd2;
				3: p = 16'hFFFF;
				4: p = 16'd65521;
				5: p = 16'd3;
				default: p = spmr_pkg::COEF_BITS'($urandom_range(2, 65535));
			endcase
			peff = (p < 2) ? 2 : p;
			case ($urandom_range(0, 5))
				0: d = 6'd0;
				1: d = 6'd1;
				2: d = 6'd32;
				3: d = spmr_pkg::DEG_BITS'($urandom_range(33, 63));
				default: d = spmr_pkg::DEG_BITS'($urandom_range(1, 8));
			endcase
			deg_eff = (d < 1) ? 1 : (d > DEG_LIMIT) ? DEG_LIMIT : d;
			cnt = spmr_pkg::CNT_BITS'($urandom_range(0, 7));
			for (k = 0; k < spmr_pkg::PACKED_TERMS; k++) begin
				pos[spmr_pkg::POS_BITS*k +: spmr_pkg::POS_BITS] =
					($urandom_range(0, 4) != 0) ?
					spmr_pkg::POS_BITS'($urandom_range(0, deg_eff - 1)) :
					spmr_pkg::POS_BITS'($urandom_range(0, 31));
				coefs[spmr_pkg::COEF_BITS*k +: spmr_pkg::COEF_BITS] =
					($urandom_range(0, 3) != 0) ?
					spmr_pkg::COEF_BITS'($urandom_range(0, peff - 1)) :
					spmr_pkg::COEF_BITS'($urandom_range(0, 65535));
			end
			write_config(p, d, cnt, pos, coefs);
			send_gaps_on  = ($urandom_range(0, 3) != 0);
			pop_stalls_on = ($urandom_range(0, 3) != 0);

			npolys = $urandom_range(3, 8);
			while (npolys > 0 && items_sent - start_count < RANDOM_ITEMS) begin
				case ($urandom_range(0, 19))
					0: plen = $urandom_range(spmr_pkg::STORE_DEPTH - 4,
					                         spmr_pkg::STORE_DEPTH + 6);
					1: plen = 1;
					default: plen = $urandom_range(1, (2 * deg_eff + 4 < 40) ?
					                                  2 * deg_eff + 4 : 40);
				endcase
				for (j = 0; j < plen; j++) begin
					c = ($urandom_range(0, 6) != 0) ?
					    spmr_pkg::COEF_BITS'($urandom_range(0, peff - 1)) :
					    spmr_pkg::COEF_BITS'($urandom_range(0, 65535));
					send_coeff(c, j == plen - 1);
				end
				// now and then let the block run dry mid-setting
				if ($urandom_range(0, 5) == 0)
					drain_results();
				npolys--;
			end
			drain_results();
		end
	endtask

	initial begin : stimulus
		arst_n      <= 1'b0;
		push        <= 1'b0;
		coefficient <= '0;
		final_coeff <= 1'b0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_registers();
		test_register_extremes();
		test_odd_registers();
		test_store_overflow();
		test_random_polys();

		if (error_count == 0 && pending_residues.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			if (pending_residues.size() != 0)
				$display("%0t: %0d residues never arrived", $time, pending_residues.size());
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
